[rtl/loom_shed_handshake_unit_defines.svh]
// ---------------------------------------------------------------------------
// loom shed handshake assertion macros
// concurrent checks on the block clock, held off while reset is high
// ---------------------------------------------------------------------------
`ifndef LOOM_SHED_HANDSHAKE_UNIT_DEFINES_SVH
`define LOOM_SHED_HANDSHAKE_UNIT_DEFINES_SVH

// plain property check
`define LSH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that holds whenever a condition is seen
`define LSH_ASSERT_ON(lbl, cond, prop, msg) \
   `LSH_ASSERT(lbl, (cond) |-> (prop), msg)

`endif

[rtl/lsh_pkg.sv]
// ---------------------------------------------------------------------------
// lsh_pkg
// shared types and constants of the loom shed handshake block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsh_pkg;

   // pattern bytes the shot can carry at most
   localparam int PATTERN_BYTES = 4;
   localparam int MAX_SEND      = (PATTERN_BYTES < 4) ? PATTERN_BYTES : 4;
   localparam int SEND_CNT_W    = $clog2(MAX_SEND + 1);
   localparam int SEND_IDX_W    = (MAX_SEND > 1) ? $clog2(MAX_SEND) : 1;

   // job queue between front and back
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   // byte count register
   localparam logic [2:0] BYTE_COUNT_MAX   = 3'd4;
   localparam logic [2:0] BYTE_COUNT_RESET = 3'd4;

   // request kinds
   localparam logic [1:0] FN_START = 2'd0;
   localparam logic [1:0] FN_BYTE  = 2'd1;
   localparam logic [1:0] FN_ABORT = 2'd2;

   // gear/lift pairs, gear in the upper bit
   localparam logic [1:0] PAIR_NONE = 2'b00;
   localparam logic [1:0] PAIR_LIFT = 2'b01;
   localparam logic [1:0] PAIR_GEAR = 2'b10;
   localparam logic [1:0] PAIR_BOTH = 2'b11;

   // result kinds
   localparam logic OUT_TX     = 1'b0;
   localparam logic OUT_STATUS = 1'b1;

   typedef enum logic [1:0] {
      ST_NEXT   = 2'd0,
      ST_PREV   = 2'd1,
      ST_REPEAT = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_ARMED = 5'b00010,
      PH_SEND  = 5'b00100,
      PH_CHECK = 5'b01000,
      PH_TURN  = 5'b10000
   } phase_type;

   typedef enum logic {
      JOB_SEND   = 1'b0,
      JOB_STATUS = 1'b1
   } job_kind_type;

   typedef struct packed {
      job_kind_type            kind;
      logic [31:0]             pattern;
      logic [SEND_CNT_W-1:0]   count;
      status_type              status;
   } job_type;

endpackage

`default_nettype wire

[rtl/lsh_channels.sv]
// ---------------------------------------------------------------------------
// lsh channels
// request and response handshake channels of the loom shed block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// request channel: start, received byte or abort
interface lsh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  rx_byte;
   logic [31:0] shafts;

   modport source (output valid, func, rx_byte, shafts, input ready);
   modport sink   (input valid, func, rx_byte, shafts, output ready);
endinterface

// response channel: transmit byte or shot status
interface lsh_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_kind;
   logic [7:0] tx_byte;
   logic [1:0] status;
   logic       last;

   modport source (output valid, out_kind, tx_byte, status, last, input ready);
   modport sink   (input valid, out_kind, tx_byte, status, last, output ready);
endinterface

`default_nettype wire

[rtl/lsh_front.sv]
// ---------------------------------------------------------------------------
// lsh_front
// takes requests, runs the shot phase machine and queues output jobs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsh_front (
   input  wire               clock,
   input  wire               reset,
   lsh_req_if.sink           req_ch,
   input  wire               csr_valid,
   input  wire [2:0]         csr_data,
   input  wire               job_full,
   output logic              job_push,
   output lsh_pkg::job_type  job_data
);
   import lsh_pkg::*;

   phase_type             phase_ff, phase_in;
   logic                  gear_ff, gear_in;
   logic                  lift_ff, lift_in;
   logic                  fwd_ff, fwd_in;
   logic                  repeat_ff, repeat_in;
   logic [31:0]           pattern_ff, pattern_in;
   logic [2:0]            byte_count_ff, byte_count_in;
   logic                  accept;
   logic [1:0]            pair;
   logic [SEND_CNT_W-1:0] send_count;

   assign req_ch.ready = !job_full;
   assign accept       = req_ch.valid && !job_full;
   assign pair         = req_ch.rx_byte[1:0];

   // byte count register, clamped on write
   always_comb begin
      byte_count_in = byte_count_ff;
      if (csr_valid) begin
         byte_count_in = (csr_data > BYTE_COUNT_MAX) ? BYTE_COUNT_MAX : csr_data;
      end
   end

   // bytes actually sent per shot
   always_comb begin
      if (32'(byte_count_ff) > MAX_SEND) begin
         send_count = SEND_CNT_W'(MAX_SEND);
      end else begin
         send_count = SEND_CNT_W'(byte_count_ff);
      end
   end

   // phase machine and job generation
   always_comb begin
      logic finish;
      finish         = 1'b0;
      phase_in       = phase_ff;
      gear_in        = gear_ff;
      lift_in        = lift_ff;
      fwd_in         = fwd_ff;
      repeat_in      = repeat_ff;
      pattern_in     = pattern_ff;
      job_push       = 1'b0;
      job_data.kind    = JOB_SEND;
      job_data.pattern = pattern_ff;
      job_data.count   = send_count;
      job_data.status  = ST_NEXT;
      if (accept) begin
         case (req_ch.func)
            FN_START: begin
               pattern_in = req_ch.shafts;
               phase_in   = PH_ARMED;
               gear_in    = 1'b0;
               lift_in    = 1'b0;
               repeat_in  = 1'b0;
            end
            FN_ABORT: begin
               if (phase_ff != PH_IDLE) begin
                  phase_in        = PH_IDLE;
                  job_push        = 1'b1;
                  job_data.kind   = JOB_STATUS;
                  job_data.status = ST_REPEAT;
               end
            end
            FN_BYTE: begin
               if (phase_ff != PH_IDLE && pair != {gear_ff, lift_ff}) begin
                  gear_in = pair[1];
                  lift_in = pair[0];
                  case (phase_ff)
                     PH_ARMED: begin
                        if (pair == PAIR_LIFT) begin
                           phase_in = PH_SEND;
                           job_push = (send_count != '0);
                        end else if (pair == PAIR_GEAR) begin
                           phase_in = PH_TURN;
                        end
                     end
                     PH_SEND: begin
                        if (pair == PAIR_GEAR) begin
                           phase_in = PH_CHECK;
                        end else if (pair == PAIR_NONE) begin
                           finish = 1'b1;
                        end
                     end
                     PH_CHECK: begin
                        if (pair == PAIR_BOTH) begin
                           repeat_in = 1'b1;
                           finish    = 1'b1;
                        end else if (pair == PAIR_NONE) begin
                           finish = 1'b1;
                        end
                     end
                     PH_TURN: begin
                        if (pair == PAIR_NONE) begin
                           fwd_in = !fwd_ff;
                           finish = 1'b1;
                        end else if (pair == PAIR_BOTH) begin
                           repeat_in = 1'b1;
                           finish    = 1'b1;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
      // shot end: next unless exactly one of repeat and backward
      if (finish) begin
         phase_in        = PH_IDLE;
         job_push        = 1'b1;
         job_data.kind   = JOB_STATUS;
         job_data.status = (repeat_in ^ !fwd_in) ? ST_PREV : ST_NEXT;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         gear_ff       <= 1'b0;
         lift_ff       <= 1'b0;
         fwd_ff        <= 1'b1;
         repeat_ff     <= 1'b0;
         byte_count_ff <= BYTE_COUNT_RESET;
      end else begin
         phase_ff      <= phase_in;
         gear_ff       <= gear_in;
         lift_ff       <= lift_in;
         fwd_ff        <= fwd_in;
         repeat_ff     <= repeat_in;
         byte_count_ff <= byte_count_in;
      end
   end

   // shot pattern
   always_ff @(posedge clock) begin
      pattern_ff <= pattern_in;
   end

endmodule

`default_nettype wire

[rtl/lsh_job_fifo.sv]
// ---------------------------------------------------------------------------
// lsh_job_fifo
// short queue of output jobs between the front and the back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsh_job_fifo (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  lsh_pkg::job_type  push_data,
   output logic              full,
   input  wire               pop,
   output lsh_pkg::job_type  pop_data,
   output logic              empty
);
   import lsh_pkg::*;

   job_type                mem_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == JOB_CNT_W'(JOB_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[rtl/lsh_back.sv]
// ---------------------------------------------------------------------------
// lsh_back
// turns queued jobs into response items through an output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "loom_shed_handshake_unit_defines.svh"

module lsh_back (
   input  wire               clock,
   input  wire               reset,
   input  lsh_pkg::job_type  job_data,
   input  wire               job_empty,
   output logic              job_pop,
   lsh_rsp_if.source         rsp_ch
);
   import lsh_pkg::*;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  kind_ff, kind_in;
   logic [7:0]            tx_ff, tx_in;
   logic [1:0]            status_ff, status_in;
   logic                  last_ff, last_in;
   logic [SEND_IDX_W-1:0] idx_ff, idx_in;
   logic                  load;
   logic                  send_last;

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_kind = kind_ff;
   assign rsp_ch.tx_byte  = tx_ff;
   assign rsp_ch.status   = status_ff;
   assign rsp_ch.last     = last_ff;

   // output register free or draining this cycle
   assign load      = !job_empty && (!rsp_valid_ff || rsp_ch.ready);
   assign send_last = (SEND_CNT_W'(idx_ff) + SEND_CNT_W'(1)) == job_data.count;

   // next response item from the queue head
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      tx_in        = tx_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      job_pop      = 1'b0;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         if (job_data.kind == JOB_SEND) begin
            kind_in   = OUT_TX;
            tx_in     = job_data.pattern[idx_ff * 8 +: 8];
            status_in = ST_NEXT;
            last_in   = send_last;
            if (send_last) begin
               job_pop = 1'b1;
               idx_in  = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end else begin
            kind_in   = OUT_STATUS;
            tx_in     = 8'h00;
            status_in = job_data.status;
            last_in   = 1'b1;
            job_pop   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      tx_ff     <= tx_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   // checks
   `LSH_ASSERT_ON(a_status_is_last, rsp_valid_ff && kind_ff == OUT_STATUS, last_ff, "status not last")
   `LSH_ASSERT_ON(a_status_no_byte, rsp_valid_ff && kind_ff == OUT_STATUS, tx_ff == 8'h00, "status carries byte")
   `LSH_ASSERT_ON(a_tx_no_status, rsp_valid_ff && kind_ff == OUT_TX, status_ff == ST_NEXT, "byte carries status")
   `LSH_ASSERT(a_mid_send_held, idx_ff != '0 |-> !job_empty, "send job left queue early")

endmodule

`default_nettype wire

[rtl/loom_shed_handshake_unit.sv]
// ---------------------------------------------------------------------------
// loom_shed_handshake_unit
// loom side handshake for one weft shot
// ---------------------------------------------------------------------------
// usage
//   req_ch carries requests: start shot with the shaft pattern, received loom
//   byte (gear in bit 1, lift in bit 0) or abort. rsp_ch returns transmit bytes
//   of the pattern, least significant first, and shot status items, each
//   run of results closed by last.
//   csr_data sets the number of pattern bytes per shot (clamped to 4), taken
//   on any cycle csr_valid is high; csr_ready is always high.
// timing
//   one request per cycle while the job queue is not full. results pass the job
//   queue and output register, then one per cycle while rsp_ch.ready is high.
//   a four entry job queue sits between the phase machine and the output
//   register; req_ch.ready drops only while that queue is full.
// reset
//   synchronous, active high: idle, levels low, direction forward, byte
//   count 4, queue and output register empty.
// stalls
//   while rsp_ch.ready is low the result holds; requests keep being taken
//   until the job queue fills.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module loom_shed_handshake_unit (
   input  wire        clock,
   input  wire        reset,
   lsh_req_if.sink    req_ch,
   lsh_rsp_if.source  rsp_ch,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [2:0]  csr_data
);
   import lsh_pkg::*;

   logic    push;
   logic    full;
   logic    pop;
   logic    empty;
   job_type push_job;
   job_type head_job;

   assign csr_ready = 1'b1;

   // phase machine
   lsh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .job_full  (full),
      .job_push  (push),
      .job_data  (push_job)
   );

   // job queue
   lsh_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (full),
      .pop       (pop),
      .pop_data  (head_job),
      .empty     (empty)
   );

   // result emission
   lsh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_data  (head_job),
      .job_empty (empty),
      .job_pop   (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

[verif/tb_loom_shed_handshake_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_loom_shed_handshake_unit
// self-checking bench for the loom shed handshake. a stimulus process queues
// requests (directed shots first, then random shots and noise over several
// byte count settings), a driver offers them with random gaps, and every
// response is checked against a prediction of the shot phases, the pattern
// bytes and the status.
// ---------------------------------------------------------------------------
module tb_loom_shed_handshake_unit;
   import lsh_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int LIMIT_NS       = 5_000_000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int CHOKE_CYCLES   = 80;
   localparam int PHASE_REQUESTS = 85;
   localparam int MAX_REPORTS    = 10;

   // func code with no meaning to the block
   localparam logic [1:0] FN_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  func;
      logic [7:0]  rx_byte;
      logic [31:0] shafts;
   } loom_request_type;

   typedef struct {
      logic       out_kind;
      logic [7:0] tx_byte;
      status_type status;
      logic       last;
   } shed_result_type;

   logic       clock;
   logic       reset;
   logic       csr_valid;
   logic       csr_ready;
   logic [2:0] csr_data;

   lsh_req_if req_ch ();
   lsh_rsp_if rsp_ch ();

   loom_shed_handshake_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // request and result bookkeeping
   loom_request_type pending_requests[$];
   shed_result_type  due_results[$];
   loom_request_type next_request;
   shed_result_type  want;
   bit            req_busy;
   bit            req_taken;
   bit            csr_taken;
   bit            choke_go;
   bit            choke_on;
   int            req_gap;
   int            rsp_hold;
   int            idle_odds;
   int            mismatches;

   // predicted shed state
   phase_type     shed_phase;
   logic          shed_gear;
   logic          shed_lift;
   logic          shed_forward;
   logic          shed_repeat;
   logic [31:0]   shed_pattern;
   logic [2:0]    shed_bytes;

   // clock
   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   task automatic post_result(input logic kind, input logic [7:0] tx, input status_type st,
                              input logic fin);
      shed_result_type r;
      r.out_kind = kind;
      r.tx_byte  = tx;
      r.status   = st;
      r.last     = fin;
      due_results.push_back(r);
   endtask

   // shot end: next when repeat and backward are both set or both clear, else previous
   task automatic close_shot();
      shed_phase = PH_IDLE;
      post_result(OUT_STATUS, 8'h00, (shed_repeat ^ ~shed_forward) ? ST_PREV : ST_NEXT, 1'b1);
   endtask

   task automatic advance_shed(input logic [1:0] fn, input logic [7:0] rx,
                               input logic [31:0] shafts);
      logic [1:0] pair;
      int         n;
      pair = rx[1:0];
      case (fn)
         FN_START: begin
            shed_pattern = shafts;
            shed_phase   = PH_ARMED;
            shed_gear    = 1'b0;
            shed_lift    = 1'b0;
            shed_repeat  = 1'b0;
         end
         FN_ABORT: begin
            if (shed_phase != PH_IDLE) begin
               shed_phase = PH_IDLE;
               post_result(OUT_STATUS, 8'h00, ST_REPEAT, 1'b1);
            end
         end
         FN_BYTE: begin
            // only a changed gear/lift pair moves the machine
            if (shed_phase != PH_IDLE && pair != {shed_gear, shed_lift}) begin
               shed_gear = pair[1];
               shed_lift = pair[0];
               case (shed_phase)
                  PH_ARMED: begin
                     if (pair == PAIR_LIFT) begin
                        shed_phase = PH_SEND;
                        n = shed_bytes;
                        if (n > MAX_SEND) n = MAX_SEND;
                        for (int i = 0; i < n; i++)
                           post_result(OUT_TX, shed_pattern[8*i +: 8], ST_NEXT, i == n - 1);
                     end else if (pair == PAIR_GEAR) begin
                        shed_phase = PH_TURN;
                     end
                  end
                  PH_SEND: begin
                     if (pair == PAIR_GEAR) shed_phase = PH_CHECK;
                     else if (pair == PAIR_NONE) close_shot();
                  end
                  PH_CHECK: begin
                     if (pair == PAIR_BOTH) begin
                        shed_repeat = 1'b1;
                        close_shot();
                     end else if (pair == PAIR_NONE) begin
                        close_shot();
                     end
                  end
                  PH_TURN: begin
                     if (pair == PAIR_NONE) begin
                        shed_forward = ~shed_forward;
                        close_shot();
                     end else if (pair == PAIR_BOTH) begin
                        shed_repeat = 1'b1;
                        close_shot();
                     end
                  end
                  default: shed_phase = PH_IDLE;
               endcase
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   task automatic push_req(input logic [1:0] fn, input logic [7:0] rx, input logic [31:0] shafts);
      loom_request_type r;
      r.func    = fn;
      r.rx_byte = rx;
      r.shafts  = shafts;
      pending_requests.push_back(r);
   endtask

   // received byte carrying a pair, with an occasional stray byte before it
   // and an occasional repeat of the same pair after it
   task automatic push_pair(input logic [1:0] pair, inout int count);
      logic [7:0] rx;
      if ($urandom_range(0, 5) == 0) begin
         push_req(FN_BYTE, 8'($urandom), $urandom);
         count++;
      end
      rx = {6'($urandom_range(0, 63)), pair};
      push_req(FN_BYTE, rx, $urandom);
      count++;
      if ($urandom_range(0, 7) == 0)
         push_req(FN_BYTE, {6'($urandom_range(0, 63)), pair}, $urandom);
   endtask

   // one shot with random pattern along a random well-formed route
   task automatic queue_shot(inout int count);
      int         route;
      logic [1:0] closer;
      push_req(FN_START, 8'($urandom), $urandom);
      count++;
      route  = $urandom_range(0, 9);
      closer = ($urandom_range(0, 1) == 0) ? PAIR_BOTH : PAIR_NONE;
      if (route < 3) begin
         push_pair(PAIR_LIFT, count);
         push_pair(PAIR_GEAR, count);
         push_pair(closer, count);
      end else if (route < 5) begin
         push_pair(PAIR_LIFT, count);
         push_pair(PAIR_NONE, count);
      end else if (route < 8) begin
         push_pair(PAIR_GEAR, count);
         push_pair(closer, count);
      end else if (route == 8) begin
         push_pair(PAIR_LIFT, count);
         push_req(FN_ABORT, 8'($urandom), $urandom);
         count++;
      end else begin
         // left open, the next start drops it
         push_pair(2'($urandom_range(0, 3)), count);
      end
   endtask

   task automatic write_byte_count(input logic [2:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(negedge clock); while (!csr_taken);
      csr_valid <= 1'b0;
   endtask

   // all requests taken, all results back, then let the block settle
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_busy || due_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_busy || req_taken) begin
         req_busy = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            next_request = pending_requests.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.func    <= next_request.func;
            req_ch.rx_byte <= next_request.rx_byte;
            req_ch.shafts  <= next_request.shafts;
            req_busy = 1'b1;
            if (idle_odds > 0 && $urandom_range(1, 100) <= idle_odds)
               req_gap = $urandom_range(1, 11);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // response ready, with random stalls and the long hold-off
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (choke_on) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (idle_odds > 0 && $urandom_range(1, 100) <= idle_odds)
            rsp_hold = $urandom_range(1, 11);
      end
   end

   initial begin : rsp_choke
      wait (choke_go);
      @(posedge clock);
      choke_on = 1'b1;
      repeat (CHOKE_CYCLES) @(posedge clock);
      choke_on = 1'b0;
   end

   // ------------------------------------------------------------------------
   // monitor: predict on accepted requests, check accepted responses
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      req_taken = 1'b0;
      csr_taken = 1'b0;
      if (reset) begin
         shed_phase   = PH_IDLE;
         shed_gear    = 1'b0;
         shed_lift    = 1'b0;
         shed_forward = 1'b1;
         shed_repeat  = 1'b0;
         shed_pattern = '0;
         shed_bytes   = BYTE_COUNT_RESET;
         due_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            csr_taken  = 1'b1;
            shed_bytes = (csr_data > BYTE_COUNT_MAX) ? BYTE_COUNT_MAX : csr_data;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response: kind %0d tx %02h status %0d last %0d",
                           rsp_ch.out_kind, rsp_ch.tx_byte, rsp_ch.status, rsp_ch.last);
            end else begin
               want = due_results.pop_front();
               if (rsp_ch.out_kind !== want.out_kind || rsp_ch.tx_byte !== want.tx_byte ||
                   rsp_ch.status !== want.status || rsp_ch.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("response mismatch at %0t: expected kind %0d tx %02h status %0d",
                              $realtime, want.out_kind, want.tx_byte, want.status,
                              " last %0d, got kind %0d tx %02h status %0d last %0d",
                              want.last, rsp_ch.out_kind, rsp_ch.tx_byte, rsp_ch.status,
                              rsp_ch.last);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            advance_shed(req_ch.func, req_ch.rx_byte, req_ch.shafts);
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int         count;
      logic [1:0] fn;
      clock          = 1'b0;
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_data       = 3'd0;
      req_ch.valid   = 1'b0;
      req_ch.func    = FN_START;
      req_ch.rx_byte = 8'h00;
      req_ch.shafts  = 32'h0;
      rsp_ch.ready   = 1'b0;
      idle_odds      = 12;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // idle cases: byte, abort and unused func are all ignored
      push_req(FN_BYTE, 8'hFF, 32'h0);
      push_req(FN_ABORT, 8'h00, 32'hFFFF_FFFF);
      push_req(FN_UNUSED, 8'hFF, 32'hFFFF_FFFF);
      // full pattern, check phase closed with both: repeat
      push_req(FN_START, 8'h00, 32'hFFFF_FFFF);
      push_req(FN_BYTE, 8'h01, 32'h0);
      push_req(FN_BYTE, 8'h02, 32'h0);
      push_req(FN_BYTE, 8'hFF, 32'h0);
      // same pair ignored, turn phase closed with none flips direction
      push_req(FN_START, 8'hFF, 32'h0000_0000);
      push_req(FN_BYTE, 8'h00, 32'h0);
      push_req(FN_BYTE, 8'hFE, 32'h0);
      push_req(FN_BYTE, 8'h00, 32'h0);
      // both while armed only moves levels, send closed with none
      push_req(FN_START, 8'h00, 32'h80FF_0001);
      push_req(FN_BYTE, 8'h03, 32'h0);
      push_req(FN_BYTE, 8'h01, 32'h0);
      push_req(FN_BYTE, 8'hFC, 32'h0);
      // turn closed with both while running backward
      push_req(FN_START, 8'h00, 32'h1234_5678);
      push_req(FN_BYTE, 8'h02, 32'h0);
      push_req(FN_BYTE, 8'h03, 32'h0);
      // start while busy drops the shot, then abort while sending
      push_req(FN_START, 8'h00, 32'hDEAD_BEEF);
      push_req(FN_START, 8'h00, 32'h0F0F_F0F0);
      push_req(FN_BYTE, 8'h01, 32'h0);
      push_req(FN_ABORT, 8'hA5, 32'h0);
      // check phase closed with none
      push_req(FN_START, 8'h00, 32'h5555_AAAA);
      push_req(FN_BYTE, 8'h01, 32'h0);
      push_req(FN_BYTE, 8'h02, 32'h0);
      push_req(FN_BYTE, 8'h00, 32'h0);
      wait_drained();

      // zero byte count: entering send gives no transmit bytes
      write_byte_count(3'd0);
      push_req(FN_START, 8'h00, 32'hC0DE_F00D);
      push_req(FN_BYTE, 8'h01, 32'h0);
      push_req(FN_BYTE, 8'h00, 32'h0);
      wait_drained();

      // write above the limit, held at four
      write_byte_count(3'd7);
      push_req(FN_START, 8'h00, 32'h0102_0304);
      push_req(FN_BYTE, 8'h01, 32'h0);
      push_req(FN_BYTE, 8'h00, 32'h0);

      // random phases over several byte counts, the last one without idling
      for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
         wait_drained();
         write_byte_count((phase_idx < 3) ? 3'(phase_idx + 1) : 3'($urandom_range(0, 7)));
         idle_odds = (phase_idx == 3) ? 0 : (phase_idx == 2) ? 30 : 12;
         count = 0;
         while (count < PHASE_REQUESTS) begin
            if ($urandom_range(0, 4) == 0) begin
               fn = 2'($urandom_range(0, 3));
               push_req(fn, 8'($urandom), $urandom);
               if (fn != FN_UNUSED) count++;
            end else begin
               queue_shot(count);
            end
         end
         // long receiver hold-off so the job queue fills and stalls requests
         if (phase_idx == 1) choke_go = 1'b1;
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatches == 0 && due_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // run limit
   initial begin : watchdog
      #(LIMIT_NS);
      $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/lsh_pkg.sv
rtl/lsh_channels.sv
rtl/lsh_front.sv
rtl/lsh_job_fifo.sv
rtl/lsh_back.sv
rtl/loom_shed_handshake_unit.sv
verif/tb_loom_shed_handshake_unit.sv
